FILE: hdl/fdr_pkg.sv
// Shared types, character codes and constants of the frame deframer and router.
package fdr_pkg;

  // Byte role tags
  typedef enum logic [3:0] {
    ROLE_HEAD    = 4'd0,
    ROLE_LENGTH  = 4'd1,
    ROLE_ADDRLEN = 4'd2,
    ROLE_ADDR    = 4'd3,
    ROLE_PORT    = 4'd4,
    ROLE_MSGLEN  = 4'd5,
    ROLE_PAYLOAD = 4'd6,
    ROLE_CRC     = 4'd7,
    ROLE_TAIL    = 4'd8
  } role_t;

  // Frame verdict codes; the first failing check wins
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MARK  = 2'd1,
    STATUS_BAD_LEN   = 2'd2,
    STATUS_ADDR_LONG = 2'd3
  } status_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_LOCAL_PORT     = 1'b0,
    REG_FORWARD_ENABLE = 1'b1
  } cfg_reg_t;

  localparam int CFG_DATA_W = 8;

  // Frame marker characters
  localparam logic [7:0] CHAR_HEAD0 = 8'h23;  // '#'
  localparam logic [7:0] CHAR_HEAD1 = 8'h24;  // '$'
  localparam logic [7:0] CHAR_TAIL0 = 8'h40;  // '@'
  localparam logic [7:0] CHAR_TAIL1 = 8'h21;  // '!'
  localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

  // Longest address that still passes the frame check
  localparam logic [7:0] MAX_ADDRESS = 8'd32;

  // Node number digits
  localparam int          NODE_DIGITS = 5;
  localparam logic [16:0] NODE_W0     = 17'd10000;
  localparam logic [16:0] NODE_W1     = 17'd1000;
  localparam logic [16:0] NODE_W2     = 17'd100;
  localparam logic [16:0] NODE_W3     = 17'd10;
  localparam logic [15:0] NODE_NONE   = 16'hFFFF;

  // Depth of each item queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    role_t       byte_role;
    logic        frame_done;
    status_t     status;
    logic        to_local;
    logic        to_forward;
    logic [15:0] node_number;
    logic        node_valid;
  } out_item_t;

  // Classified item between front and back
  typedef struct packed {
    logic [7:0]                   out_byte;
    role_t                        byte_role;
    logic                         frame_done;
    status_t                      status;
    logic                         to_local;
    logic                         to_forward;
    logic [NODE_DIGITS-1:0][3:0]  digits;
    logic                         node_ok;
  } mid_item_t;

endpackage

FILE: hdl/fdr_queue.sv
// Small first-in first-out item queue with registered storage.
module fdr_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = store[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Write entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

FILE: hdl/fdr_front.sv
// Front part: frame tracking, byte role tagging and frame verdict.
module fdr_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  fdr_pkg::in_item_t               in_item,
  output logic                            full,
  input  logic                            cfg_write,
  input  fdr_pkg::cfg_reg_t               cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                            mid_push,
  output fdr_pkg::mid_item_t              mid_item,
  input  logic                            mid_full
);

  // Configuration
  logic [7:0] local_port;
  logic       forward_enable;

  // Frame state
  logic [15:0]     byte_count;
  logic [15:0]     declared_length;
  logic [7:0]      address_length;
  logic [7:0]      port_value;
  logic [4:0][3:0] digit_window;
  logic [2:0]      digit_good_run;
  logic            head_good;
  logic [7:0]      previous_byte;

  // State as updated by the current byte
  logic [15:0]     declared_now;
  logic [7:0]      alen_now;
  logic [7:0]      port_now;
  logic [4:0][3:0] window_now;
  logic [2:0]      run_now;
  logic            head_now;

  logic [15:0]     byte_count_next;
  logic [15:0]     declared_length_next;
  logic [7:0]      address_length_next;
  logic [7:0]      port_value_next;
  logic [4:0][3:0] digit_window_next;
  logic [2:0]      digit_good_run_next;
  logic            head_good_next;
  logic [7:0]      previous_byte_next;

  logic [7:0]       b;
  logic             last;
  logic             accept;
  logic [8:0]       addr_end;
  logic [16:0]      p_plus1;
  logic [16:0]      p_plus2;
  logic [16:0]      p_plus4;
  logic             is_digit;
  fdr_pkg::role_t   role;
  fdr_pkg::status_t status;

  assign b        = in_item.in_byte;
  assign last     = in_item.in_last;
  assign full     = mid_full;
  assign accept   = push && !mid_full;
  assign addr_end = {1'b0, address_length} + 9'd5;
  assign p_plus1  = {1'b0, byte_count} + 17'd1;
  assign p_plus2  = {1'b0, byte_count} + 17'd2;
  assign p_plus4  = {1'b0, byte_count} + 17'd4;
  assign is_digit = (b >= fdr_pkg::CHAR_ZERO) && (b <= fdr_pkg::CHAR_NINE);

  // Tag the byte and fold it into the frame state
  always_comb begin
    role         = fdr_pkg::ROLE_PAYLOAD;
    declared_now = declared_length;
    alen_now     = address_length;
    port_now     = port_value;
    window_now   = digit_window;
    run_now      = digit_good_run;
    head_now     = head_good;
    priority if (byte_count <= 16'd1) begin
      role = fdr_pkg::ROLE_HEAD;
      if (byte_count == 16'd0) begin
        head_now = (b == fdr_pkg::CHAR_HEAD0);
      end else begin
        head_now = head_good && (b == fdr_pkg::CHAR_HEAD1);
      end
    end else if (byte_count <= 16'd3) begin
      role = fdr_pkg::ROLE_LENGTH;
      if (byte_count == 16'd2) begin
        declared_now = {declared_length[15:8], b};
      end else begin
        declared_now = {b, declared_length[7:0]};
      end
    end else if (byte_count == 16'd4) begin
      role     = fdr_pkg::ROLE_ADDRLEN;
      alen_now = b;
    end else if (byte_count < 16'(addr_end)) begin
      role = fdr_pkg::ROLE_ADDR;
      for (int i = 0; i < 4; i++) begin
        window_now[i] = digit_window[i+1];
      end
      if (is_digit) begin
        window_now[4] = 4'(b - fdr_pkg::CHAR_ZERO);
        run_now       = (digit_good_run < 3'd5) ? digit_good_run + 3'd1 : digit_good_run;
      end else begin
        window_now[4] = 4'd0;
        run_now       = 3'd0;
      end
    end else if (byte_count == 16'(addr_end)) begin
      role     = fdr_pkg::ROLE_PORT;
      port_now = b;
    end else if ((byte_count == 16'(addr_end + 9'd1)) ||
                 (byte_count == 16'(addr_end + 9'd2))) begin
      role = fdr_pkg::ROLE_MSGLEN;
    end else if (p_plus2 >= {1'b0, declared_length}) begin
      role = fdr_pkg::ROLE_TAIL;
    end else if (p_plus4 >= {1'b0, declared_length}) begin
      role = fdr_pkg::ROLE_CRC;
    end else begin
      role = fdr_pkg::ROLE_PAYLOAD;
    end
  end

  // Check markers, length and address length
  always_comb begin
    priority if ((p_plus1 < 17'd4) || !head_now ||
                 (previous_byte != fdr_pkg::CHAR_TAIL0) || (b != fdr_pkg::CHAR_TAIL1)) begin
      status = fdr_pkg::STATUS_BAD_MARK;
    end else if (p_plus1 != {1'b0, declared_now}) begin
      status = fdr_pkg::STATUS_BAD_LEN;
    end else if (alen_now > fdr_pkg::MAX_ADDRESS) begin
      status = fdr_pkg::STATUS_ADDR_LONG;
    end else begin
      status = fdr_pkg::STATUS_OK;
    end
  end

  // Build the classified item; verdict fields only on the last byte
  always_comb begin
    mid_item            = '0;
    mid_item.out_byte   = b;
    mid_item.byte_role  = role;
    mid_item.frame_done = last;
    mid_item.digits     = window_now;
    if (last) begin
      mid_item.status     = status;
      mid_item.to_local   = (status == fdr_pkg::STATUS_OK) && (port_now == local_port);
      mid_item.to_forward = (status == fdr_pkg::STATUS_OK) && (port_now != local_port) &&
                            forward_enable;
      mid_item.node_ok    = (alen_now >= 8'd5) && (run_now >= 3'd5);
    end
  end

  assign mid_push = accept;

  // Next frame state: clear after the last byte
  always_comb begin
    if (last) begin
      byte_count_next      = '0;
      declared_length_next = '0;
      address_length_next  = '0;
      port_value_next      = '0;
      digit_window_next    = '0;
      digit_good_run_next  = '0;
      head_good_next       = 1'b0;
      previous_byte_next   = '0;
    end else begin
      byte_count_next      = (byte_count == 16'hFFFF) ? byte_count : byte_count + 16'd1;
      declared_length_next = declared_now;
      address_length_next  = alen_now;
      port_value_next      = port_now;
      digit_window_next    = window_now;
      digit_good_run_next  = run_now;
      head_good_next       = head_now;
      previous_byte_next   = b;
    end
  end

  // Hold frame state between accepted items
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count      <= '0;
      declared_length <= '0;
      address_length  <= '0;
      port_value      <= '0;
      digit_window    <= '0;
      digit_good_run  <= '0;
      head_good       <= 1'b0;
      previous_byte   <= '0;
    end else if (accept) begin
      byte_count      <= byte_count_next;
      declared_length <= declared_length_next;
      address_length  <= address_length_next;
      port_value      <= port_value_next;
      digit_window    <= digit_window_next;
      digit_good_run  <= digit_good_run_next;
      head_good       <= head_good_next;
      previous_byte   <= previous_byte_next;
    end
  end

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      local_port     <= '0;
      forward_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fdr_pkg::REG_LOCAL_PORT: begin
          local_port <= cfg_data[7:0];
        end
        fdr_pkg::REG_FORWARD_ENABLE: begin
          forward_enable <= cfg_data[0];
        end
      endcase
    end
  end

endmodule

FILE: hdl/fdr_back.sv
// Back part: node number evaluation and result hand-off.
module fdr_back (
  input  fdr_pkg::mid_item_t mid_item,
  input  logic               mid_empty,
  output logic               mid_pop,
  output logic               res_push,
  output fdr_pkg::out_item_t res_item,
  input  logic               res_full
);

  logic [16:0] p0;
  logic [16:0] p1;
  logic [16:0] p2;
  logic [16:0] p3;
  logic [16:0] node_sum;
  logic        move;

  // Weight the five address digits
  assign p0       = 17'(mid_item.digits[0]) * fdr_pkg::NODE_W0;
  assign p1       = 17'(mid_item.digits[1]) * fdr_pkg::NODE_W1;
  assign p2       = 17'(mid_item.digits[2]) * fdr_pkg::NODE_W2;
  assign p3       = 17'(mid_item.digits[3]) * fdr_pkg::NODE_W3;
  assign node_sum = p0 + p1 + p2 + p3 + 17'(mid_item.digits[4]);

  // Move one item when the result queue has room
  assign move     = !mid_empty && !res_full;
  assign mid_pop  = move;
  assign res_push = move;

  // Assemble the result item
  always_comb begin
    res_item             = '0;
    res_item.out_byte    = mid_item.out_byte;
    res_item.byte_role   = mid_item.byte_role;
    res_item.frame_done  = mid_item.frame_done;
    res_item.status      = mid_item.status;
    res_item.to_local    = mid_item.to_local;
    res_item.to_forward  = mid_item.to_forward;
    res_item.node_valid  = mid_item.node_ok;
    if (mid_item.frame_done) begin
      res_item.node_number = mid_item.node_ok ? node_sum[15:0] : fdr_pkg::NODE_NONE;
    end
  end

endmodule

FILE: hdl/frame_deframer_router_unit.sv
// Frame deframer and router top level: front tagger, item queues and back stage.
// Takes one frame byte per cycle and returns one tagged result per byte, in order, at a
// sustained rate of one item per cycle while the result side keeps popping. An accepted
// byte is written into the queue between front and back, then moved into the result
// queue, from which it shows on the result ports. Each queue holds QUEUE_DEPTH items.
// With the result side stalled, the input keeps taking bytes until both queues are
// full, that is 2*QUEUE_DEPTH items in flight. Verdict fields (status, routing, node
// number) are valid only on the item that carries frame_done; they read zero elsewhere.
// local_port and forward_enable are written through cfg_write/cfg_index/cfg_data and must
// only change while no item is in flight.
module frame_deframer_router_unit #(
  parameter int QUEUE_DEPTH = fdr_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  fdr_pkg::in_item_t              in_item,
  output logic                           full,
  output logic                           empty,
  input  logic                           pop,
  output fdr_pkg::out_item_t             out_item,
  input  logic                           cfg_write,
  input  fdr_pkg::cfg_reg_t              cfg_index,
  input  logic [fdr_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int MID_W = $bits(fdr_pkg::mid_item_t);
  localparam int OUT_W = $bits(fdr_pkg::out_item_t);

  logic               mid_push;
  fdr_pkg::mid_item_t mid_wr;
  logic               mid_full;
  logic               mid_pop;
  logic [MID_W-1:0]   mid_rd;
  logic               mid_empty;
  logic               res_push;
  fdr_pkg::out_item_t res_wr;
  logic               res_full;
  logic [OUT_W-1:0]   res_rd;

  // Accept and classify bytes
  fdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_item   (in_item),
    .full      (full),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mid_push  (mid_push),
    .mid_item  (mid_wr),
    .mid_full  (mid_full)
  );

  // Decouple front and back
  fdr_queue #(
    .WIDTH (MID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (mid_push),
    .wr_data (mid_wr),
    .full    (mid_full),
    .pop     (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  // Finish results
  fdr_back u_back (
    .mid_item  (fdr_pkg::mid_item_t'(mid_rd)),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .res_push  (res_push),
    .res_item  (res_wr),
    .res_full  (res_full)
  );

  // Hold results until popped
  fdr_queue #(
    .WIDTH (OUT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign out_item = fdr_pkg::out_item_t'(res_rd);

endmodule

FILE: hdl/fdr_checker.sv
// Port-level checks for the frame deframer and router, bound to the top level.
module fdr_checker (
  input logic               clk,
  input logic               rst,
  input logic               empty,
  input logic               pop,
  input fdr_pkg::out_item_t out_item
);

  // Reset drains the result side
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed before pop");

  // Verdict fields stay zero away from the last byte
  a_no_verdict: assert property (@(posedge clk) disable iff (rst)
    (!empty && !out_item.frame_done) |->
      (out_item.status == fdr_pkg::STATUS_OK && !out_item.to_local &&
       !out_item.to_forward && out_item.node_number == 16'd0 && !out_item.node_valid))
    else $error("verdict fields set on a byte that is not the last");

  // Route only good frames, and to one place at most
  a_route: assert property (@(posedge clk) disable iff (rst)
    (!empty && (out_item.to_local || out_item.to_forward)) |->
      (out_item.status == fdr_pkg::STATUS_OK && !(out_item.to_local && out_item.to_forward)))
    else $error("bad frame routed or routed twice");

  // An invalid node number reads as all ones
  a_node_none: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_item.frame_done && !out_item.node_valid) |->
      (out_item.node_number == fdr_pkg::NODE_NONE))
    else $error("invalid node number not all ones");

endmodule

bind frame_deframer_router_unit fdr_checker u_fdr_checker (
  .clk      (clk),
  .rst      (rst),
  .empty    (empty),
  .pop      (pop),
  .out_item (out_item)
);

FILE: sim/frame_deframer_router_unit_tb.sv
// Testbench for the frame deframer and router: directed and random frames checked by a predictor.
module frame_deframer_router_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fdr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 300;
  localparam int PHASES         = 6;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  logic                  empty;
  logic                  pop;
  logic                  cfg_write;
  in_item_t              in_item;
  out_item_t             out_item;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Predictor state: register mirror and frame tracking
  logic [7:0]  cfg_local_port;
  logic        cfg_fwd_en;
  logic [15:0] fr_count;
  logic [15:0] fr_decl_len;
  logic [7:0]  fr_addr_len;
  logic [7:0]  fr_port;
  logic [7:0]  fr_msg_len;
  logic [7:0]  fr_prev;
  logic [3:0]  fr_digits [0:4];
  logic [2:0]  fr_digit_run;
  logic        fr_head_ok;

  out_item_t   pending_tags [$];
  stim_row_t   directed_bytes [$];
  logic [7:0]  frame_bytes [$];
  int          errors;
  int          quiet_cycles;
  int          in_gap_pct;
  int          out_stall_pct;

  frame_deframer_router_unit DUT (
    .clk(clk),
    .rst(rst),
    .push(push),
    .in_item(in_item),
    .full(full),
    .empty(empty),
    .pop(pop),
    .out_item(out_item),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drop all per-frame tracking
  function automatic void clear_frame();
    fr_count = '0;
    fr_decl_len = '0;
    fr_addr_len = '0;
    fr_port = '0;
    fr_msg_len = '0;
    for (int i = 0; i < 5; i++) fr_digits[i] = '0;
    fr_digit_run = '0;
    fr_head_ok = 1'b0;
    fr_prev = '0;
  endfunction

  // Tag one accepted byte, advance the frame state and give the verdict on the last byte
  function automatic out_item_t tag_frame_byte(input in_item_t it);
    out_item_t  r;
    logic [7:0] b;
    int         pos;
    int         alen;
    int         dlen;
    int         acc;
    b = it.in_byte;
    pos = int'(fr_count);
    alen = int'(fr_addr_len);
    dlen = int'(fr_decl_len);
    r = '0;
    r.out_byte = b;
    r.frame_done = it.in_last;
    if (pos <= 1) begin
      r.byte_role = ROLE_HEAD;
      if (pos == 0) fr_head_ok = (b == CHAR_HEAD0);
      else fr_head_ok = fr_head_ok && (b == CHAR_HEAD1);
    end else if (pos <= 3) begin
      r.byte_role = ROLE_LENGTH;
      if (pos == 2) fr_decl_len[7:0] = b;
      else fr_decl_len[15:8] = b;
    end else if (pos == 4) begin
      r.byte_role = ROLE_ADDRLEN;
      fr_addr_len = b;
    end else if (pos < 5 + alen) begin
      r.byte_role = ROLE_ADDR;
      for (int i = 0; i < 4; i++) fr_digits[i] = fr_digits[i+1];
      if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
        fr_digits[4] = b[3:0];
        if (fr_digit_run < 3'd5) fr_digit_run = fr_digit_run + 3'd1;
      end else begin
        fr_digits[4] = '0;
        fr_digit_run = '0;
      end
    end else if (pos == 5 + alen) begin
      r.byte_role = ROLE_PORT;
      fr_port = b;
    end else if (pos == 6 + alen) begin
      r.byte_role = ROLE_MSGLEN;
      fr_msg_len = b;
    end else if (pos == 7 + alen) begin
      r.byte_role = ROLE_MSGLEN;
    end else if (pos + 2 >= dlen) begin
      r.byte_role = ROLE_TAIL;
    end else if (pos + 4 >= dlen) begin
      r.byte_role = ROLE_CRC;
    end else begin
      r.byte_role = ROLE_PAYLOAD;
    end

    if (it.in_last) begin
      // First failing check wins
      if (pos + 1 < 4 || !fr_head_ok || fr_prev != CHAR_TAIL0 || b != CHAR_TAIL1)
        r.status = STATUS_BAD_MARK;
      else if (pos + 1 != int'(fr_decl_len))
        r.status = STATUS_BAD_LEN;
      else if (fr_addr_len > MAX_ADDRESS)
        r.status = STATUS_ADDR_LONG;
      else
        r.status = STATUS_OK;
      if (r.status == STATUS_OK) begin
        if (fr_port == cfg_local_port) r.to_local = 1'b1;
        else if (cfg_fwd_en) r.to_forward = 1'b1;
      end
      if (fr_addr_len >= 8'd5 && fr_digit_run >= 3'd5) begin
        acc = 10000 * fr_digits[0] + 1000 * fr_digits[1] + 100 * fr_digits[2] +
              10 * fr_digits[3] + fr_digits[4];
        r.node_valid = 1'b1;
        r.node_number = acc[15:0];
      end else begin
        r.node_number = NODE_NONE;
      end
      clear_frame();
    end else begin
      if (fr_count != 16'hFFFF) fr_count = fr_count + 16'd1;
      fr_prev = b;
    end
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] b, input logic last,
                                  input bit typed = 1'b0, input out_item_t want = '0);
    stim_row_t row;
    row.item.in_byte = b;
    row.item.in_last = last;
    row.typed = typed;
    row.want = want;
    directed_bytes.push_back(row);
  endfunction

  // Lay out a well-formed frame with random content
  function automatic void build_good_frame(input int alen, input int plen);
    int total;
    total = alen + plen + 12;
    frame_bytes.delete();
    frame_bytes.push_back(CHAR_HEAD0);
    frame_bytes.push_back(CHAR_HEAD1);
    frame_bytes.push_back(total[7:0]);
    frame_bytes.push_back(total[15:8]);
    frame_bytes.push_back(alen[7:0]);
    for (int i = 0; i < alen; i++) begin
      if ($urandom_range(1, 100) <= 85)
        frame_bytes.push_back(8'(CHAR_ZERO + $urandom_range(0, 9)));
      else frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 1)) frame_bytes.push_back(cfg_local_port);
    else frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(plen[7:0]);
    frame_bytes.push_back(8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : 0));
    for (int i = 0; i < plen + 2; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
    frame_bytes.push_back(CHAR_TAIL0);
    frame_bytes.push_back(CHAR_TAIL1);
  endfunction

  // Mostly good frames; the rest get a broken marker, a wrong length, a cut, or are noise
  function automatic void build_random_frame();
    int          kind;
    int          pick;
    int          alen;
    int          idx;
    int          cut;
    logic [15:0] dlen;
    kind = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (pick < 65) alen = $urandom_range(0, 10);
    else if (pick < 85) alen = $urandom_range(11, 40);
    else if (pick < 97) alen = $urandom_range(30, 34);
    else alen = 255;
    build_good_frame(alen, $urandom_range(0, 10));
    if (kind >= 94) begin
      frame_bytes.delete();
      cut = $urandom_range(1, 12);
      for (int i = 0; i < cut; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (cut >= 2 && $urandom_range(0, 1)) begin
        frame_bytes[0] = CHAR_HEAD0;
        frame_bytes[1] = CHAR_HEAD1;
      end
    end else if (kind >= 88) begin
      cut = $urandom_range(1, frame_bytes.size() - 1);
      while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
      if (cut >= 4 && $urandom_range(0, 1)) begin
        frame_bytes[cut-2] = CHAR_TAIL0;
        frame_bytes[cut-1] = CHAR_TAIL1;
      end
    end else if (kind >= 80) begin
      if ($urandom_range(0, 1)) dlen = 16'($urandom_range(0, 65535));
      else dlen = 16'(frame_bytes.size() + $urandom_range(1, 3));
      frame_bytes[2] = dlen[7:0];
      frame_bytes[3] = dlen[15:8];
    end else if (kind >= 70) begin
      case ($urandom_range(0, 3))
        0: idx = 0;
        1: idx = 1;
        2: idx = frame_bytes.size() - 2;
        default: idx = frame_bytes.size() - 1;
      endcase
      frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
    end
  endfunction

  // Offer one item, hold it until taken, and queue its expected tag
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    if (in_gap_pct != 0 && $urandom_range(1, 100) <= in_gap_pct) begin
      push = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    push = 1'b1;
    in_item = it;
    @(posedge clk);
    while (full) @(posedge clk);
    predicted = tag_frame_byte(it);
    pending_tags.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic send_frame();
    in_item_t it;
    for (int i = 0; i < frame_bytes.size(); i++) begin
      it.in_byte = frame_bytes[i];
      it.in_last = (i == frame_bytes.size() - 1);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Wait out every expected tag plus the pipeline depth
  task automatic drain_and_settle();
    push = 1'b0;
    while (pending_tags.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] value);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    if (idx == REG_LOCAL_PORT) cfg_local_port = value;
    else cfg_fwd_en = value[0];
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Stall the result side in random bursts
  initial begin : result_drain
    int hold;
    hold = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        pop = 1'b0;
        hold--;
      end else if (out_stall_pct != 0 && $urandom_range(1, 100) <= out_stall_pct) begin
        pop = 1'b0;
        hold = $urandom_range(0, 3);
      end else begin
        pop = 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest expected tag
  always @(posedge clk) begin : result_check
    out_item_t exp_tag;
    if (!rst && pop && !empty) begin
      if (pending_tags.size() == 0) begin
        $display("%0t ns: unexpected item, expected none actual %h", $time, out_item);
        errors++;
      end else begin
        exp_tag = pending_tags.pop_front();
        check_field("out_byte", 16'(exp_tag.out_byte), 16'(out_item.out_byte));
        check_field("byte_role", 16'(exp_tag.byte_role), 16'(out_item.byte_role));
        check_field("frame_done", 16'(exp_tag.frame_done), 16'(out_item.frame_done));
        check_field("status", 16'(exp_tag.status), 16'(out_item.status));
        check_field("to_local", 16'(exp_tag.to_local), 16'(out_item.to_local));
        check_field("to_forward", 16'(exp_tag.to_forward), 16'(out_item.to_forward));
        check_field("node_number", exp_tag.node_number, out_item.node_number);
        check_field("node_valid", 16'(exp_tag.node_valid), 16'(out_item.node_valid));
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL frame_deframer_router_unit");
      $finish;
    end
  end

  initial begin : stimulus
    int         sent;
    logic [7:0] port_sel;
    logic       fwd_sel;
    logic [7:0] fwd_data;
    errors = 0;
    quiet_cycles = 0;
    in_gap_pct = 25;
    out_stall_pct = 25;
    rst = 1'b1;
    push = 1'b0;
    in_item = '0;
    cfg_write = 1'b0;
    cfg_index = REG_LOCAL_PORT;
    cfg_data = '0;
    cfg_local_port = 8'h00;
    cfg_fwd_en = 1'b1;
    clear_frame();
    repeat (10) @(negedge clk);
    rst = 1'b0;
    write_reg(REG_LOCAL_PORT, 8'h00);
    write_reg(REG_FORWARD_ENABLE, 8'h01);

    // One-byte frames at the byte extremes: too short, bad marker
    add_row(8'h00, 1'b1, 1'b1,
            '{8'h00, ROLE_HEAD, 1'b1, STATUS_BAD_MARK, 1'b0, 1'b0, NODE_NONE, 1'b0});
    add_row(8'hFF, 1'b1, 1'b1,
            '{8'hFF, ROLE_HEAD, 1'b1, STATUS_BAD_MARK, 1'b0, 1'b0, NODE_NONE, 1'b0});
    // Good frame, address "12345", port 0 goes to the local controller
    add_row(CHAR_HEAD0, 1'b0);
    add_row(CHAR_HEAD1, 1'b0);
    add_row(8'd17, 1'b0);
    add_row(8'd0, 1'b0);
    add_row(8'd5, 1'b0);
    add_row(8'h31, 1'b0);
    add_row(8'h32, 1'b0);
    add_row(8'h33, 1'b0);
    add_row(8'h34, 1'b0);
    add_row(8'h35, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'h00, 1'b0);
    add_row(8'hA5, 1'b0);
    add_row(8'h5A, 1'b0);
    add_row(CHAR_TAIL0, 1'b0);
    add_row(CHAR_TAIL1, 1'b1, 1'b1,
            '{CHAR_TAIL1, ROLE_TAIL, 1'b1, STATUS_OK, 1'b1, 1'b0, 16'd12345, 1'b1});
    // Four-byte frame with good markers: the tail lands in the length field
    add_row(CHAR_HEAD0, 1'b0);
    add_row(CHAR_HEAD1, 1'b0);
    add_row(CHAR_TAIL0, 1'b0);
    add_row(CHAR_TAIL1, 1'b1, 1'b1,
            '{CHAR_TAIL1, ROLE_LENGTH, 1'b1, STATUS_BAD_LEN, 1'b0, 1'b0, NODE_NONE, 1'b0});
    foreach (directed_bytes[i])
      send_item(directed_bytes[i].item, directed_bytes[i].typed, directed_bytes[i].want);
    drain_and_settle();

    // Random frames under several register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin port_sel = 8'h00; fwd_sel = 1'b1; in_gap_pct = 20; out_stall_pct = 20; end
        1: begin port_sel = 8'hFF; fwd_sel = 1'b0; in_gap_pct = 30; out_stall_pct = 30; end
        2: begin
          port_sel = 8'($urandom_range(0, 255));
          fwd_sel = 1'b1;
          in_gap_pct = 0;
          out_stall_pct = 0;
        end
        3: begin
          port_sel = 8'($urandom_range(0, 255));
          fwd_sel = 1'b0;
          in_gap_pct = 10;
          out_stall_pct = 40;
        end
        4: begin port_sel = 8'hFF; fwd_sel = 1'b1; in_gap_pct = 40; out_stall_pct = 10; end
        default: begin port_sel = 8'h00; fwd_sel = 1'b0; in_gap_pct = 0; out_stall_pct = 0; end
      endcase
      fwd_data = 8'($urandom_range(0, 255));
      fwd_data[0] = fwd_sel;
      write_reg(REG_LOCAL_PORT, port_sel);
      write_reg(REG_FORWARD_ENABLE, fwd_data);

      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_random_frame();
        sent += frame_bytes.size();
        send_frame();
      end
      drain_and_settle();
    end

    if (errors == 0) $display("PASS frame_deframer_router_unit");
    else $display("FAIL frame_deframer_router_unit");
    $finish;
  end

endmodule

FILE: sim.f
hdl/fdr_pkg.sv
hdl/fdr_queue.sv
hdl/fdr_front.sv
hdl/fdr_back.sv
hdl/frame_deframer_router_unit.sv
hdl/fdr_checker.sv
sim/frame_deframer_router_unit_tb.sv
